>>> hdl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

  localparam int DataW = 16;

  typedef logic signed [DataW-1:0] elem_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } mat_t;

  typedef struct packed {
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;
    elem_t quat_w;
    logic  degenerate;
  } quat_t;

endpackage
`default_nettype wire

>>> hdl/rmq_if.sv
`default_nettype none
interface rmq_mat_if import rmq_pkg::*;;
  logic valid;
  logic ready;
  elem_t m00;
  elem_t m01;
  elem_t m02;
  elem_t m10;
  elem_t m11;
  elem_t m12;
  elem_t m20;
  elem_t m21;
  elem_t m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*;;
  logic valid;
  logic ready;
  elem_t quat_x;
  elem_t quat_y;
  elem_t quat_z;
  elem_t quat_w;
  logic degenerate;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate, output ready);
endinterface
`default_nettype wire

>>> hdl/rmq_sqrt_stage.sv
`default_nettype none
// One step of a restoring square root, two radicand bits per step.
module rmq_sqrt_stage import rmq_pkg::*; #(
  parameter int RadW = 34,
  parameter int RootW = 17,
  parameter int Step = 0
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [RadW-1:0]   rad_in,
  input  wire logic [RootW+1:0]  rem_in,
  input  wire logic [RootW-1:0]  root_in,
  output logic      [RadW-1:0]   rad_out,
  output logic      [RootW+1:0]  rem_out,
  output logic      [RootW-1:0]  root_out
);

  logic [RootW+1:0] trial;
  logic [RootW+1:0] cand;

  always_comb begin
    cand  = {rem_in[RootW-1:0], rad_in[RadW-1 -: 2]};
    trial = {root_in, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out <= rad_in << 2;
      if (cand >= trial) begin
        rem_out  <= cand - trial;
        root_out <= {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_out  <= cand;
        root_out <= {root_in[RootW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/rmq_div_stage.sv
`default_nettype none
// One step of a restoring divider producing one quotient bit.
module rmq_div_stage import rmq_pkg::*; #(
  parameter int NumW = 32,
  parameter int DenW = 18
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [NumW-1:0] num_in,
  input  wire logic [DenW:0]   rem_in,
  input  wire logic [DenW-1:0] den_in,
  output logic      [NumW-1:0] num_out,
  output logic      [DenW:0]   rem_out,
  output logic      [DenW-1:0] den_out
);

  logic [DenW+1:0] cand;

  always_comb begin
    cand = {rem_in, num_in[NumW-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      if (cand >= {2'b00, den_in}) begin
        rem_out <= (DenW+1)'(cand - {2'b00, den_in});
        num_out <= {num_in[NumW-2:0], 1'b1};
      end else begin
        rem_out <= cand[DenW:0];
        num_out <= {num_in[NumW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/rotation_matrix_to_quaternion.sv
`default_nettype none
// Rotation matrix to quaternion converter, trace method, fixed point.
//
// Channels: in_ch carries one word per 3x3 matrix (nine signed elements with
// FRAC_BITS fraction bits); out_ch carries one word per quaternion (x, y, z,
// w, saturated to 16 bits) plus a degenerate flag. Words move when valid and
// ready are both high.
//
// Throughput is one word per cycle when the receiver does not stall. From the
// accepting edge to the output word the pipe has two setup stages, one stage
// per root bit of the square root (RootW stages, 18 at the default), one stage
// per quotient bit of the four dividers (NumW stages, FRAC_BITS + 18), which
// run side by side, and the output register.
// Rounding and saturation are combinational in front of the output register.
//
// Reset clears every valid bit; payload registers are not reset. When the
// receiver stalls, the whole pipe holds (one global enable), so no word is
// lost or repeated; in_ch.ready follows out_ch.ready whenever the output
// register is full, and stays high while the output register is empty.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic       clk,
  input  wire logic       rst,
  rmq_mat_if.sink         in_ch,
  rmq_quat_if.source      out_ch
);

  // The argument stays below 2^17 + one, so ArgW holds it, and the radicand
  // arg << FRAC_BITS fits in 2*ArgW bits.
  localparam int ArgW  = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 18;
  localparam int RadW  = 2 * ArgW;
  localparam int RootW = ArgW;
  localparam int DenW  = RootW + 1;
  localparam int NumW  = 18 + FRAC_BITS;   // |n| < 2^17, scaled
  localparam int QW    = NumW;
  localparam int Depth = RootW + NumW + 2;

  // Global stall: advance when the output register can take a word.
  logic en;
  logic [Depth-1:0] vld;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: trace, select, argument, numerators.
  typedef struct packed {
    logic                  pos;     // argument usable
    logic [1:0]            sel;     // 3 = w large (trace branch), else index
    logic [ArgW-1:0]       arg;
    logic signed [17:0]    n0;      // numerators for x, y, z, w order
    logic signed [17:0]    n1;
    logic signed [17:0]    n2;
    logic signed [17:0]    n3;
  } s1_t;

  s1_t s1;
  s1_t s1_next;

  always_comb begin
    logic signed [17:0] a00;
    logic signed [17:0] a11;
    logic signed [17:0] a22;
    logic signed [17:0] trc;
    logic signed [ArgW+1:0] arg;
    logic signed [ArgW+1:0] one;
    logic [1:0] i;
    a00 = 18'(in_ch.m00);
    a11 = 18'(in_ch.m11);
    a22 = 18'(in_ch.m22);
    trc = a00 + a11 + a22;
    one = '0;
    one[FRAC_BITS] = 1'b1;
    i = 2'd0;
    s1_next = '0;
    if (trc > 0) begin
      arg = (ArgW+2)'(trc) + one;
      s1_next.sel = 2'd3;
      s1_next.n0 = 18'(in_ch.m21) - 18'(in_ch.m12);
      s1_next.n1 = 18'(in_ch.m02) - 18'(in_ch.m20);
      s1_next.n2 = 18'(in_ch.m10) - 18'(in_ch.m01);
      s1_next.n3 = '0;
    end else begin
      if (in_ch.m00 < in_ch.m11) i = (in_ch.m11 < in_ch.m22) ? 2'd2 : 2'd1;
      else i = (in_ch.m00 < in_ch.m22) ? 2'd2 : 2'd0;
      s1_next.sel = i;
      case (i)
        2'd0: begin
          arg = (ArgW+2)'(a00) - (ArgW+2)'(a11) - (ArgW+2)'(a22) + one;
          s1_next.n3 = 18'(in_ch.m21) - 18'(in_ch.m12);
          s1_next.n1 = 18'(in_ch.m10) + 18'(in_ch.m01);
          s1_next.n2 = 18'(in_ch.m20) + 18'(in_ch.m02);
          s1_next.n0 = '0;
        end
        2'd1: begin
          arg = (ArgW+2)'(a11) - (ArgW+2)'(a22) - (ArgW+2)'(a00) + one;
          s1_next.n3 = 18'(in_ch.m02) - 18'(in_ch.m20);
          s1_next.n2 = 18'(in_ch.m21) + 18'(in_ch.m12);
          s1_next.n0 = 18'(in_ch.m01) + 18'(in_ch.m10);
          s1_next.n1 = '0;
        end
        default: begin
          arg = (ArgW+2)'(a22) - (ArgW+2)'(a00) - (ArgW+2)'(a11) + one;
          s1_next.n3 = 18'(in_ch.m10) - 18'(in_ch.m01);
          s1_next.n0 = 18'(in_ch.m02) + 18'(in_ch.m20);
          s1_next.n1 = 18'(in_ch.m12) + 18'(in_ch.m21);
          s1_next.n2 = '0;
        end
      endcase
    end
    s1_next.pos = arg > 0;
    s1_next.arg = s1_next.pos ? ArgW'(arg) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (en) s1 <= s1_next;
  end

  // Square root pipeline, side info carried alongside.
  logic [RadW-1:0]  rad  [RootW+1];
  logic [RootW+1:0] rem  [RootW+1];
  logic [RootW-1:0] root [RootW+1];
  s1_t              sq_s [RootW+1];

  assign rad[0]  = RadW'(s1.arg) << FRAC_BITS;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sq_s[0] = s1;

  for (genvar g = 0; g < RootW; g++) begin : g_sqrt
    rmq_sqrt_stage #(.RadW(RadW), .RootW(RootW), .Step(g)) u_st (
      .clk, .en,
      .rad_in(rad[g]), .rem_in(rem[g]), .root_in(root[g]),
      .rad_out(rad[g+1]), .rem_out(rem[g+1]), .root_out(root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) sq_s[g+1] <= sq_s[g];
    end
  end

  // Divider setup stage: magnitudes, signs, degenerate decision.
  typedef struct packed {
    logic            degen;
    logic [1:0]      sel;
    logic [RootW-1:0] s;
    logic [3:0]      neg;
  } dv_t;

  dv_t               dv [NumW+1];
  logic [NumW-1:0]   dnum [4][NumW+1];
  logic [DenW:0]     drem [4][NumW+1];
  logic [DenW-1:0]   dden [4][NumW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].degen <= !sq_s[RootW].pos || (root[RootW] == '0);
      dv[0].sel   <= sq_s[RootW].sel;
      dv[0].s     <= root[RootW];
      dv[0].neg   <= {sq_s[RootW].n3[17], sq_s[RootW].n2[17],
                      sq_s[RootW].n1[17], sq_s[RootW].n0[17]};
      for (int c = 0; c < 4; c++) begin
        drem[c][0] <= '0;
        dden[c][0] <= {root[RootW], 1'b0};
      end
      dnum[0][0] <= NumW'(sq_s[RootW].n0[17] ? -sq_s[RootW].n0 : sq_s[RootW].n0)
                    << FRAC_BITS;
      dnum[1][0] <= NumW'(sq_s[RootW].n1[17] ? -sq_s[RootW].n1 : sq_s[RootW].n1)
                    << FRAC_BITS;
      dnum[2][0] <= NumW'(sq_s[RootW].n2[17] ? -sq_s[RootW].n2 : sq_s[RootW].n2)
                    << FRAC_BITS;
      dnum[3][0] <= NumW'(sq_s[RootW].n3[17] ? -sq_s[RootW].n3 : sq_s[RootW].n3)
                    << FRAC_BITS;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    for (genvar g = 0; g < NumW; g++) begin : g_div
      rmq_div_stage #(.NumW(NumW), .DenW(DenW)) u_dv (
        .clk, .en,
        .num_in(dnum[c][g]), .rem_in(drem[c][g]), .den_in(dden[c][g]),
        .num_out(dnum[c][g+1]), .rem_out(drem[c][g+1]), .den_out(dden[c][g+1])
      );
    end
  end

  for (genvar g = 0; g < NumW; g++) begin : g_dvs
    always_ff @(posedge clk) begin
      if (en) dv[g+1] <= dv[g];
    end
  end

  // Rounding: ties away from zero means remainder*2 >= den.
  logic [QW:0] qr [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [DenW+1:0] r2;
      r2 = {drem[c][NumW], 1'b0};
      qr[c] = {1'b0, dnum[c][NumW]} +
              ((r2 >= {2'b00, dden[c][NumW]}) ? (QW+1)'(1) : '0);
    end
  end

  function automatic elem_t sat_mag(input logic [QW:0] m, input logic n);
    if (n) return (m > (QW+1)'(32768)) ? elem_t'(-32768) : elem_t'(-$signed({1'b0, m}));
    else return (m > (QW+1)'(32767)) ? elem_t'(32767) : elem_t'(m);
  endfunction

  quat_t res;
  always_comb begin
    elem_t q [4];
    elem_t half;
    dv_t d;
    d = dv[NumW];
    half = ((d.s >> 1) > RootW'(32767)) ? elem_t'(32767) : elem_t'(d.s >> 1);
    for (int c = 0; c < 4; c++) q[c] = sat_mag(qr[c], d.neg[c]);
    case (d.sel)
      2'd0: q[0] = half;
      2'd1: q[1] = half;
      2'd2: q[2] = half;
      default: q[3] = half;
    endcase
    res.quat_x = d.degen ? '0 : q[0];
    res.quat_y = d.degen ? '0 : q[1];
    res.quat_z = d.degen ? '0 : q[2];
    res.quat_w = d.degen ? '0 : q[3];
    res.degenerate = d.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vld[Depth-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.quat_x <= res.quat_x;
      out_ch.quat_y <= res.quat_y;
      out_ch.quat_z <= res.quat_z;
      out_ch.quat_w <= res.quat_w;
      out_ch.degenerate <= res.degenerate;
    end
  end

  // A stalled output word keeps its valid.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("output word dropped");
  // Degenerate words carry zero components (x and w are checked).
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.degenerate |-> out_ch.quat_x == '0 && out_ch.quat_w == '0)
    else $error("degenerate word with nonzero components");
  // Pipe does not move while stalled.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("pipe moved during stall");

endmodule
`default_nettype wire
